// ===== hdl/nlc_pkg.sv =====
// shared types and codes for the name lookup cache
// used by nlc_cmp, name_lookup_cache_lru and the port checker
package nlc_pkg;

   // kinds of request item
   localparam logic [1:0] KIND_LOOKUP    = 2'd0;
   localparam logic [1:0] KIND_ENTER     = 2'd1;
   localparam logic [1:0] KIND_PURGE_NM  = 2'd2;
   localparam logic [1:0] KIND_PURGE_ND  = 2'd3;

   // status codes of a response item
   localparam logic [2:0] ST_MISS      = 3'd0;
   localparam logic [2:0] ST_EXPIRED   = 3'd1;
   localparam logic [2:0] ST_NEG_HIT   = 3'd2;
   localparam logic [2:0] ST_POS_HIT   = 3'd3;
   localparam logic [2:0] ST_ENTERED   = 3'd4;
   localparam logic [2:0] ST_TOO_LONG  = 3'd5;
   localparam logic [2:0] ST_PURGED    = 3'd6;

   // configuration register indexes
   localparam logic CSR_POS_TIMEOUT = 1'b0;
   localparam logic CSR_NEG_TIMEOUT = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd3;
   localparam logic [8:0]  COUNT_MAX     = 9'd511;
   localparam logic [1:0]  CLASS_MAX     = 2'd3;

   // parameter defaults
   localparam int DEF_ENTRIES      = 256;
   localparam int DEF_CLASS_SIZE   = 100;
   localparam int DEF_MAX_NAME_LEN = 99;

   // field widths
   localparam int KEY_W   = 64;
   localparam int LEN_W   = 8;
   localparam int NODE_W  = 32;
   localparam int TIME_W  = 32;
   localparam int TO_W    = 16;
   localparam int REQ_W   = 200;
   localparam int RSP_W   = 48;

   // compare unit results
   typedef struct packed {
      logic name_hit;
      logic node_hit;
      logic expired;
   } cmp_type;

endpackage

// ===== hdl/nlc_cmp.sv =====
// compare unit shared by every step of the recency walk
// depends on nlc_pkg
module nlc_cmp (
   input  logic [nlc_pkg::LEN_W-1:0]  ent_len,
   input  logic [nlc_pkg::KEY_W-1:0]  ent_dir,
   input  logic [nlc_pkg::KEY_W-1:0]  ent_name,
   input  logic [nlc_pkg::NODE_W-1:0] ent_node,
   input  logic [nlc_pkg::TIME_W-1:0] ent_stamp,
   input  logic [nlc_pkg::LEN_W-1:0]  req_len,
   input  logic [nlc_pkg::KEY_W-1:0]  req_dir,
   input  logic [nlc_pkg::KEY_W-1:0]  req_name,
   input  logic [nlc_pkg::NODE_W-1:0] req_node,
   input  logic [nlc_pkg::TIME_W-1:0] req_now,
   input  logic [nlc_pkg::TO_W-1:0]   pos_timeout,
   input  logic [nlc_pkg::TO_W-1:0]   neg_timeout,
   output nlc_pkg::cmp_type           result
);
   import nlc_pkg::*;

   logic              used;
   logic [TIME_W-1:0] age;
   logic [TO_W-1:0]   limit;

   // entry key match and age against its timeout
   always_comb begin
      used            = (ent_len != '0);
      age             = req_now - ent_stamp;
      limit           = (ent_node != '0) ? pos_timeout : neg_timeout;
      result.name_hit = used && (ent_len == req_len) && (ent_dir == req_dir)
                        && (ent_name == req_name);
      result.node_hit = used && (req_node != '0) && (ent_node == req_node);
      result.expired  = (age >= TIME_W'(limit));
   end

endmodule

// ===== hdl/name_lookup_cache_lru.sv =====
// name lookup cache with recency order: top level, sequencer and memories
// depends on nlc_pkg and nlc_cmp
//
//  channel | direction | payload
//  req_    | in        | tuser kind, tdata keys, length, node, time
//  rsp_    | out       | tdata status, node, depth class, purge count
//  csr_    | in        | index 0 positive timeout, 1 negative timeout
//
// after reset a clearing pass over every position runs with req_tready low
// one item walks the recency list position by position (order memory,
// then entry memories, then the compare unit), up to the whole list
// a move to either end reads and writes each shifted position, a purge each freed entry
// a finished result waits in the output register; one item at a time
module name_lookup_cache_lru #(
   parameter int ENTRIES      = nlc_pkg::DEF_ENTRIES,
   parameter int CLASS_SIZE   = nlc_pkg::DEF_CLASS_SIZE,
   parameter int MAX_NAME_LEN = nlc_pkg::DEF_MAX_NAME_LEN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // dir_key, name_key, name_length, node_id, now_seconds
   input  logic [nlc_pkg::REQ_W-1:0]  req_tdata,
   // kind
   input  logic [1:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status, found_node, depth_class, purged_count
   output logic [nlc_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [nlc_pkg::TO_W-1:0]   csr_data
);
   import nlc_pkg::*;

   localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW   = IW + 1;
   localparam int CLSW = $clog2(CLASS_SIZE + 1);
   localparam logic [IW-1:0]   LAST_POS  = IW'(ENTRIES - 1);
   localparam logic [CLSW-1:0] CLS_LAST  = CLSW'(CLASS_SIZE - 1);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_W_ORD  = 4'd2;
   localparam logic [3:0] S_W_ENT  = 4'd3;
   localparam logic [3:0] S_W_CMP  = 4'd4;
   localparam logic [3:0] S_SH_RD  = 4'd5;
   localparam logic [3:0] S_SH_WR  = 4'd6;
   localparam logic [3:0] S_SH_END = 4'd7;
   localparam logic [3:0] S_CP_RD  = 4'd8;
   localparam logic [3:0] S_CP_WR  = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   // memories
   logic [LEN_W-1:0]  len_mem   [ENTRIES];
   logic [KEY_W-1:0]  dir_mem   [ENTRIES];
   logic [KEY_W-1:0]  name_mem  [ENTRIES];
   logic [NODE_W-1:0] node_mem  [ENTRIES];
   logic [TIME_W-1:0] stamp_mem [ENTRIES];
   logic [IW-1:0]     order_mem [ENTRIES];
   logic [IW-1:0]     spill_mem [ENTRIES];

   logic [LEN_W-1:0]  len_rd;
   logic [KEY_W-1:0]  dir_rd, name_rd;
   logic [NODE_W-1:0] node_rd;
   logic [TIME_W-1:0] stamp_rd;
   logic [IW-1:0]     order_rd, spill_rd;

   // request item registers
   logic [1:0]        kind_ff;
   logic [KEY_W-1:0]  dir_ff, name_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [NODE_W-1:0] node_ff;
   logic [TIME_W-1:0] now_ff;

   logic [TO_W-1:0]   pos_to_ff, neg_to_ff;

   // sequencer state
   logic [3:0]      state_ff, state_in;
   logic [IW-1:0]   pos_ff, pos_in;
   logic [IW-1:0]   q_ff, q_in;
   logic [IW-1:0]   keep_ff, keep_in;
   logic [CW-1:0]   moved_ff, moved_in;
   logic [IW-1:0]   ci_ff, ci_in;
   logic [CLSW-1:0] cls_cnt_ff, cls_cnt_in;
   logic [1:0]      cls_ff, cls_in;
   logic [IW-1:0]   cur_e_ff, cur_e_in;
   logic            front_ff, front_in;
   logic [2:0]      status_ff, status_in;
   logic [NODE_W-1:0] found_ff, found_in;
   logic [1:0]      depth_ff, depth_in;

   logic            rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   // memory ports
   logic [IW-1:0] ord_ra, ord_wa, ord_wd, ent_ra, ent_wa;
   logic          ord_we, spill_we, ent_free_we, ent_fill_we;

   cmp_type cmp;
   logic    accept, last, is_purge, walk_hit;
   logic [CW+9:0] moved_ext;
   logic [8:0]    count_out;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign last       = (pos_ff == LAST_POS);
   assign is_purge   = (kind_ff == KIND_PURGE_NM) || (kind_ff == KIND_PURGE_ND);
   assign walk_hit   = (kind_ff == KIND_PURGE_ND) ? cmp.node_hit : cmp.name_hit;
   assign moved_ext  = (CW + 10)'(moved_ff);
   assign count_out  = (moved_ext > (CW + 10)'(COUNT_MAX)) ? COUNT_MAX : moved_ext[8:0];

   nlc_cmp u_cmp (
      .ent_len     (len_rd),
      .ent_dir     (dir_rd),
      .ent_name    (name_rd),
      .ent_node    (node_rd),
      .ent_stamp   (stamp_rd),
      .req_len     (len_ff),
      .req_dir     (dir_ff),
      .req_name    (name_ff),
      .req_node    (node_ff),
      .req_now     (now_ff),
      .pos_timeout (pos_to_ff),
      .neg_timeout (neg_to_ff),
      .result      (cmp)
   );

   // next state of the sequencer and memory port control
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      q_in        = q_ff;
      keep_in     = keep_ff;
      moved_in    = moved_ff;
      ci_in       = ci_ff;
      cls_cnt_in  = cls_cnt_ff;
      cls_in      = cls_ff;
      cur_e_in    = cur_e_ff;
      front_in    = front_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      depth_in    = depth_ff;
      ord_ra      = pos_ff;
      ord_wa      = pos_ff;
      ord_wd      = pos_ff;
      ord_we      = 1'b0;
      spill_we    = 1'b0;
      ent_ra      = order_rd;
      ent_wa      = cur_e_ff;
      ent_free_we = 1'b0;
      ent_fill_we = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            ord_we      = 1'b1;
            ent_wa      = pos_ff;
            ent_free_we = 1'b1;
            pos_in      = pos_ff + 1'b1;
            if (last) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            pos_in     = '0;
            keep_in    = '0;
            moved_in   = '0;
            ci_in      = '0;
            cls_cnt_in = '0;
            cls_in     = '0;
            status_in  = ST_MISS;
            found_in   = '0;
            depth_in   = '0;
            if (accept) begin
               if (req_tuser == KIND_ENTER && (req_tdata[135:128] == '0 ||
                   req_tdata[135:128] > LEN_W'(MAX_NAME_LEN))) begin
                  status_in = ST_TOO_LONG;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_W_ORD;
               end
            end
         end
         S_W_ORD: begin
            state_in = S_W_ENT;
         end
         S_W_ENT: begin
            cur_e_in = order_rd;
            state_in = S_W_CMP;
         end
         S_W_CMP: begin
            if (is_purge) begin
               // stable compaction of the order, freed entries spill aside
               if (walk_hit) begin
                  ent_free_we = 1'b1;
                  spill_we    = 1'b1;
                  moved_in    = moved_ff + 1'b1;
               end else begin
                  ord_we  = 1'b1;
                  ord_wa  = keep_ff;
                  ord_wd  = cur_e_ff;
                  keep_in = keep_ff + 1'b1;
               end
               status_in = ST_PURGED;
            end
            if (!is_purge && walk_hit) begin
               if (kind_ff == KIND_ENTER) begin
                  ent_fill_we = 1'b1;
                  status_in   = ST_ENTERED;
                  front_in    = 1'b1;
               end else begin
                  depth_in = cls_ff;
                  if (cmp.expired) begin
                     ent_free_we = 1'b1;
                     status_in   = ST_EXPIRED;
                     front_in    = 1'b0;
                  end else begin
                     front_in  = 1'b1;
                     status_in = (node_rd == '0) ? ST_NEG_HIT : ST_POS_HIT;
                     found_in  = node_rd;
                  end
               end
               state_in = S_SH_RD;
               q_in     = front_ff ? pos_ff : pos_ff;
               if (kind_ff == KIND_ENTER || !cmp.expired) begin
                  q_in = pos_ff - 1'b1;
                  if (pos_ff == '0) state_in = S_SH_END;
               end else begin
                  q_in = pos_ff + 1'b1;
                  if (last) state_in = S_SH_END;
               end
            end else if (last) begin
               if (kind_ff == KIND_ENTER) begin
                  // miss: reuse the least recent entry
                  ent_fill_we = 1'b1;
                  status_in   = ST_ENTERED;
                  front_in    = 1'b1;
                  q_in        = pos_ff - 1'b1;
                  state_in    = S_SH_RD;
               end else if (is_purge && (walk_hit || moved_ff != '0)) begin
                  state_in = S_CP_RD;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_W_ORD;
               if (cls_cnt_ff == CLS_LAST) begin
                  cls_cnt_in = '0;
                  if (cls_ff != CLASS_MAX) cls_in = cls_ff + 1'b1;
               end else begin
                  cls_cnt_in = cls_cnt_ff + 1'b1;
               end
            end
         end
         S_SH_RD: begin
            ord_ra   = q_ff;
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            ord_we   = 1'b1;
            ord_wa   = front_ff ? q_ff + 1'b1 : q_ff - 1'b1;
            ord_wd   = order_rd;
            state_in = S_SH_RD;
            if (front_ff) begin
               q_in = q_ff - 1'b1;
               if (q_ff == '0) state_in = S_SH_END;
            end else begin
               q_in = q_ff + 1'b1;
               if (q_ff == LAST_POS) state_in = S_SH_END;
            end
         end
         S_SH_END: begin
            ord_we   = 1'b1;
            ord_wa   = front_ff ? '0 : LAST_POS;
            ord_wd   = cur_e_ff;
            state_in = S_RESP;
         end
         S_CP_RD: begin
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            ord_we   = 1'b1;
            ord_wa   = keep_ff + ci_ff;
            ord_wd   = spill_rd;
            ci_in    = ci_ff + 1'b1;
            state_in = (CW'(ci_ff) == moved_ff - 1'b1) ? S_RESP : S_CP_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_CLR;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pos_to_ff    <= TIMEOUT_RESET;
         neg_to_ff    <= TIMEOUT_RESET;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         if (state_ff == S_RESP && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POS_TIMEOUT) pos_to_ff <= csr_data;
            else                              neg_to_ff <= csr_data;
         end
      end
   end

   // working registers and the response register
   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      keep_ff    <= keep_in;
      moved_ff   <= moved_in;
      ci_ff      <= ci_in;
      cls_cnt_ff <= cls_cnt_in;
      cls_ff     <= cls_in;
      cur_e_ff   <= cur_e_in;
      front_ff   <= front_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      depth_ff   <= depth_in;
      if (accept) begin
         kind_ff <= req_tuser;
         dir_ff  <= req_tdata[63:0];
         name_ff <= req_tdata[127:64];
         len_ff  <= req_tdata[135:128];
         node_ff <= req_tdata[167:136];
         now_ff  <= req_tdata[199:168];
      end
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {2'b00, (is_purge ? count_out : 9'd0), depth_ff, found_ff,
                         status_ff};
      end
   end

   // recency order and spill memories
   always_ff @(posedge clock) begin
      if (ord_we) order_mem[ord_wa] <= ord_wd;
      order_rd <= order_mem[ord_ra];
      if (spill_we) spill_mem[moved_ff[IW-1:0]] <= cur_e_ff;
      spill_rd <= spill_mem[ci_ff];
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (ent_free_we) begin
         len_mem[ent_wa]  <= '0;
         node_mem[ent_wa] <= '0;
      end else if (ent_fill_we) begin
         len_mem[ent_wa]  <= len_ff;
         node_mem[ent_wa] <= node_ff;
      end
      if (ent_fill_we) begin
         dir_mem[ent_wa]   <= dir_ff;
         name_mem[ent_wa]  <= name_ff;
         stamp_mem[ent_wa] <= now_ff;
      end
      len_rd   <= len_mem[ent_ra];
      dir_rd   <= dir_mem[ent_ra];
      name_rd  <= name_mem[ent_ra];
      node_rd  <= node_mem[ent_ra];
      stamp_rd <= stamp_mem[ent_ra];
   end

endmodule

// ===== hdl/nlc_port_check.sv =====
// port-level checker for name_lookup_cache_lru, bound to the top level
// depends on nlc_pkg
module nlc_port_check (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [nlc_pkg::RSP_W-1:0] rsp_tdata
);
   import nlc_pkg::*;

   // a waiting result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response item changed while stalled");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // status code is one of the defined codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd7)
      else $error("undefined status code");

   // only a positive hit carries a node
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_POS_HIT |-> rsp_tdata[34:3] == '0)
      else $error("node reported without positive hit");

endmodule

bind name_lookup_cache_lru nlc_port_check u_nlc_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
